### rtl/bcmi_pkg.sv
// Package for the blink code menu indicator.
// Shared types, op codes, register indexes and limits; no dependencies.
`default_nettype none

package bcmi_pkg;

    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned SETTING_W = 4;
    localparam int unsigned STEP_W    = 6;
    localparam int unsigned MS_W      = 16;
    localparam int unsigned CFG_AW    = 2;
    localparam int unsigned CFG_DW    = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 24;

    localparam logic [SETTING_W-1:0] MAX_SETTING        = 4'd4;
    localparam bit                   ALLOW_SETTING_ZERO = 1'b1;
    localparam logic [SETTING_W-1:0] MIN_SETTING        = ALLOW_SETTING_ZERO ? 4'd0 : 4'd1;

    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_NEXT      = 3'd1,
        OP_PREV      = 3'd2,
        OP_SELECT    = 3'd3,
        OP_SETTINGS  = 3'd4,
        OP_FLASH     = 3'd5,
        OP_SET_LEVEL = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        PAT_STEADY = 2'd0,
        PAT_BLINK  = 2'd1,
        PAT_FLASH  = 2'd2
    } pattern_t;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LEVEL_HIGH   = 2'd0,
        CFG_LEVEL_LOW    = 2'd1,
        CFG_STEP_SPACING = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]           pattern_mode;
        logic [SETTING_W-1:0] setting_number;
        logic                 in_normal_mode;
        logic [LEVEL_W-1:0]   pwm_level;
    } result_t;

endpackage

`default_nettype wire

### rtl/blink_code_menu_indicator_top.sv
// Blink code menu indicator, top level. Uses bcmi_pkg, bcmi_core, bcmi_out_buf.
// The result of each accepted input beat is registered in the output stage (main or skid entry).
// Throughput: one beat per cycle while s_tready is high; each accepted beat updates the state registers.
// A two-entry output stage keeps s_tready high while one result waits.
// Reset (rst_n low, async): normal mode, steady pattern, level 0, config defaults.
`default_nettype none

module blink_code_menu_indicator_top
    import bcmi_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_AW-1:0]      cfg_addr,
    input  wire logic [CFG_DW-1:0]      cfg_wdata,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,   // op[2:0], level[12:3]
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [OUT_TDATA_W-1:0]      m_tdata    // pwm_level[9:0], in_normal_mode[10],
                                                   // setting_number[14:11], pattern_mode[16:15]
);

    logic    in_fire;
    result_t core_result, out_result;

    assign in_fire = s_tvalid && s_tready;

    bcmi_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_op     (s_tdata[2:0]),
        .in_level  (s_tdata[12:3]),
        .result    (core_result)
    );

    bcmi_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_data   (core_result),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_result};

endmodule

`default_nettype wire

### rtl/bcmi_core.sv
// State and per-beat update of the blink code menu indicator.
// Uses bcmi_pkg. Each accepted beat updates the state registers.
`default_nettype none

module bcmi_core
    import bcmi_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_AW-1:0]    cfg_addr,
    input  wire logic [CFG_DW-1:0]    cfg_wdata,
    input  wire logic                 in_fire,
    input  wire logic [2:0]           in_op,
    input  wire logic [LEVEL_W-1:0]   in_level,
    output result_t                   result
);

    logic [LEVEL_W-1:0]   level_high_reg, level_low_reg;
    logic [MS_W-1:0]      spacing_reg;

    logic                 normal_reg, normal_next;
    logic [SETTING_W-1:0] setting_reg, setting_next;
    logic [1:0]           pattern_reg, pattern_next;
    logic [SETTING_W-1:0] count_reg, count_next;
    logic [STEP_W-1:0]    step_reg, step_next;
    logic [MS_W-1:0]      elapsed_reg, elapsed_next;
    logic [LEVEL_W-1:0]   level_reg, level_next;
    logic [LEVEL_W-1:0]   saved_reg, saved_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_high_reg <= 10'd1023;
            level_low_reg  <= 10'd0;
            spacing_reg    <= 16'd250;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_addr))
                CFG_LEVEL_HIGH:   level_high_reg <= cfg_wdata[LEVEL_W-1:0];
                CFG_LEVEL_LOW:    level_low_reg  <= cfg_wdata[LEVEL_W-1:0];
                CFG_STEP_SPACING: spacing_reg    <= cfg_wdata[MS_W-1:0];
                default: ;
            endcase
        end
    end

    logic [MS_W-1:0]   elapsed_inc;
    logic [STEP_W-1:0] blink_lim, blink_s0, two_n;

    always_comb
    begin
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 16'd1;
        two_n       = {1'b0, count_reg, 1'b0};
        blink_lim   = two_n + 6'd2;
        if (count_reg == '0)
            blink_s0 = (step_reg > 6'd6) ? '0 : step_reg;
        else
            blink_s0 = (step_reg > blink_lim) ? '0 : step_reg;
    end

    always_comb
    begin
        normal_next  = normal_reg;
        setting_next = setting_reg;
        pattern_next = pattern_reg;
        count_next   = count_reg;
        step_next    = step_reg;
        elapsed_next = elapsed_reg;
        level_next   = level_reg;
        saved_next   = saved_reg;

        case (op_t'(in_op))
            OP_TICK:
            begin
                elapsed_next = elapsed_inc;
                if ((pattern_reg == PAT_BLINK || pattern_reg == PAT_FLASH)
                    && elapsed_inc > spacing_reg)
                begin
                    elapsed_next = '0;
                    if (pattern_reg == PAT_BLINK)
                    begin
                        if (count_reg == '0)
                            level_next = (blink_s0 < 6'd5) ? level_high_reg : level_low_reg;
                        else if (blink_s0 >= two_n || blink_s0[0])
                            level_next = level_low_reg;
                        else
                            level_next = level_high_reg;
                        step_next = blink_s0 + 6'd1;
                    end
                    else if (step_reg > 6'd3)
                    begin
                        step_next    = '0;
                        pattern_next = PAT_STEADY;
                        level_next   = saved_reg;
                    end
                    else
                    begin
                        level_next = (step_reg == 6'd0 || step_reg == 6'd2)
                                     ? level_high_reg : '0;
                        step_next  = step_reg + 6'd1;
                    end
                end
            end
            OP_NEXT, OP_PREV, OP_SETTINGS:
            begin
                if (!normal_reg || op_t'(in_op) == OP_SETTINGS)
                begin
                    if (op_t'(in_op) == OP_NEXT && setting_reg < MAX_SETTING)
                        setting_next = setting_reg + 4'd1;
                    else if (op_t'(in_op) == OP_PREV && setting_reg > MIN_SETTING)
                        setting_next = setting_reg - 4'd1;
                    normal_next  = (op_t'(in_op) == OP_SETTINGS) ? 1'b0 : normal_reg;
                    count_next   = setting_next;
                    pattern_next = PAT_BLINK;
                    saved_next   = level_reg;
                    elapsed_next = '0;
                    step_next    = '0;
                    level_next   = level_low_reg;
                end
            end
            OP_SELECT:
            begin
                normal_next  = 1'b1;
                pattern_next = PAT_STEADY;
                level_next   = 10'd1;
            end
            OP_FLASH:
            begin
                pattern_next = PAT_FLASH;
                saved_next   = level_reg;
                elapsed_next = '0;
                step_next    = '0;
                level_next   = level_low_reg;
            end
            OP_SET_LEVEL:
                level_next = in_level;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_reg  <= 1'b1;
            setting_reg <= MIN_SETTING;
            pattern_reg <= PAT_STEADY;
            count_reg   <= '0;
            step_reg    <= '0;
            elapsed_reg <= '0;
            level_reg   <= '0;
            saved_reg   <= '0;
        end
        else if (in_fire)
        begin
            normal_reg  <= normal_next;
            setting_reg <= setting_next;
            pattern_reg <= pattern_next;
            count_reg   <= count_next;
            step_reg    <= step_next;
            elapsed_reg <= elapsed_next;
            level_reg   <= level_next;
            saved_reg   <= saved_next;
        end
    end

    // result of the beat being accepted, captured by the output stage
    assign result.pwm_level      = level_next;
    assign result.in_normal_mode = normal_next;
    assign result.setting_number = setting_next;
    assign result.pattern_mode   = pattern_next;

endmodule

`default_nettype wire

### rtl/bcmi_out_buf.sv
// Output register with skid stage for the result stream.
// Uses bcmi_pkg for the result type.
`default_nettype none

module bcmi_out_buf
    import bcmi_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_fire,
    input  wire result_t in_data,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    output result_t      out_data
);

    logic    main_valid_reg, skid_valid_reg;
    result_t main_data_reg, skid_data_reg;
    logic    out_take;

    assign out_take  = main_valid_reg && out_ready;
    assign in_ready  = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            if (!main_valid_reg || out_take)
                main_valid_reg <= 1'b1;
            else
                skid_valid_reg <= 1'b1;
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
                skid_valid_reg <= 1'b0;
            else
                main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (!main_valid_reg || out_take)
                main_data_reg <= in_data;
            else
                skid_data_reg <= in_data;
        end
        else if (out_take && skid_valid_reg)
            main_data_reg <= skid_data_reg;
    end

endmodule

`default_nettype wire

### rtl/bcmi_checker.sv
// Port-level checks for blink_code_menu_indicator_top, attached by bind.
// Uses bcmi_pkg for widths and limits.
`default_nettype none

module bcmi_checker
    import bcmi_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_tready,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [OUT_TDATA_W-1:0] m_tdata
);

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result beat dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("stalled result beat changed");

    a_setting_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[14:11] <= MAX_SETTING && m_tdata[14:11] >= MIN_SETTING
                      && m_tdata[16:15] != 2'd3))
        else $error("setting or pattern out of range");

    a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

endmodule

bind blink_code_menu_indicator_top bcmi_checker u_bcmi_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
